FILE: hdl/schit_pkg.sv
// ----------------------------------------------------------------------------
// schit_pkg
// Widths, stage records and arithmetic steps of the segment/circle hit test.
// ----------------------------------------------------------------------------
package schit_pkg;

    localparam int CB  = 16;
    localparam int DW  = CB + 1;
    localparam int QW  = CB + 1;
    localparam int TW  = 2 * CB + 1;
    localparam int SW  = TW + 2;
    localparam int PW  = CB + 2;
    localparam int RW  = 16;
    localparam int R2W = 2 * RW;
    localparam int MW  = (2 * PW + 1 > R2W) ? 2 * PW + 1 : R2W + 1;

    typedef struct packed {
        logic [TW-1:0]        rem;
        logic [QW-1:0]        quo;
        logic [QW-1:0]        ad;
        logic                 neg;
        logic signed [CB-1:0] org;
    } t_lane;

    typedef struct packed {
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [R2W-1:0]       r2;
        logic                 hit_e;
        logic                 ok;
        logic [TW-1:0]        t0;
        logic [TW-1:0]        t1;
    } t_carry;

    function automatic t_lane div_step(t_lane l, logic b, logic [TW-1:0] t0,
                                       logic [TW-1:0] t1);
        logic [SW-1:0] s;
        logic [SW-1:0] t1x1;
        logic [SW-1:0] t1x2;
        t_lane         n;
        s    = {1'b0, l.rem, 1'b0} + (b ? {2'b00, t0} : {SW{1'b0}});
        t1x1 = {2'b00, t1};
        t1x2 = {1'b0, t1, 1'b0};
        n    = l;
        if (s >= t1x2) begin
            n.rem = TW'(s - t1x2);
            n.quo = {l.quo[QW-2:0], 1'b0} + QW'(2);
        end else if (s >= t1x1) begin
            n.rem = TW'(s - t1x1);
            n.quo = {l.quo[QW-2:0], 1'b0} + QW'(1);
        end else begin
            n.rem = TW'(s);
            n.quo = {l.quo[QW-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic signed [PW-1:0] proj_point(t_lane l);
        logic signed [PW-1:0] org;
        logic signed [PW-1:0] q;
        logic signed [PW-1:0] base;
        logic signed [PW-1:0] lo;
        org  = {{2{l.org[CB-1]}}, l.org};
        q    = $signed({1'b0, l.quo});
        base = l.neg ? org - q : org + q;
        lo   = l.neg ? base - PW'(1) : base;
        return (l.rem == '0) ? base : (lo[PW-1] ? lo + PW'(1) : lo);
    endfunction

endpackage

FILE: hdl/segment_circle_hit_test_unit.sv
// ----------------------------------------------------------------------------
// segment_circle_hit_test_unit
// Pipelined test of whether a circle touches a segment, exact integer math.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  item in  | start, busy (always low) | i_seg_start_x/y, i_seg_end_x/y,
//           |                          | i_centre_x/y, i_circle_radius
//  item out | o_hit_valid strobe       | o_hit
//
//  One item enters per cycle. The projection divider retires one bit of
//  the segment span per stage, QW stages for x and y. Reset clears the
//  valid bits only; the pipeline never stalls.
// ----------------------------------------------------------------------------
module segment_circle_hit_test_unit
    import schit_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CB-1:0] i_seg_start_x,
    input  logic signed [CB-1:0] i_seg_start_y,
    input  logic signed [CB-1:0] i_seg_end_x,
    input  logic signed [CB-1:0] i_seg_end_y,
    input  logic signed [CB-1:0] i_centre_x,
    input  logic signed [CB-1:0] i_centre_y,
    input  logic [RW-1:0]        i_circle_radius,
    output logic                 o_hit_valid,
    output logic                 o_hit
);

    localparam int LAT = QW + 6;

    logic                 r_v1;
    logic signed [DW-1:0] r_ex, r_ey, r_ax, r_ay, r_bx, r_by;
    logic signed [CB-1:0] r_x0, r_y0, r_cx1, r_cy1;
    logic [RW-1:0]        r_rad;

    logic                   r_v2;
    logic signed [2*DW-1:0] r_ex2, r_ey2, r_tx, r_ty, r_a2x, r_a2y, r_b2x, r_b2y;
    logic [R2W-1:0]         r_r2;
    logic [QW-1:0]          r_adx, r_ady;
    logic                   r_negx, r_negy;
    logic signed [CB-1:0]   r_x0b, r_y0b, r_cx2, r_cy2;

    logic signed [TW:0]   n_t0;
    logic [TW-1:0]        n_t1;
    logic                 n_hit_e;

    logic   r_vd [0:QW];
    t_carry r_cr [0:QW];
    t_lane  r_lx [0:QW];
    t_lane  r_ly [0:QW];

    logic                   r_vf1, r_vf2;
    logic signed [PW-1:0]   r_dx, r_dy;
    logic signed [2*PW-1:0] r_sx, r_sy;
    logic [R2W-1:0]         r_r2f1, r_r2f2;
    logic                   r_he1, r_he2, r_ok1, r_ok2;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex  <= DW'(i_seg_end_x) - DW'(i_seg_start_x);
        r_ey  <= DW'(i_seg_end_y) - DW'(i_seg_start_y);
        r_ax  <= DW'(i_centre_x) - DW'(i_seg_start_x);
        r_ay  <= DW'(i_centre_y) - DW'(i_seg_start_y);
        r_bx  <= DW'(i_seg_end_x) - DW'(i_centre_x);
        r_by  <= DW'(i_seg_end_y) - DW'(i_centre_y);
        r_x0  <= i_seg_start_x;
        r_y0  <= i_seg_start_y;
        r_cx1 <= i_centre_x;
        r_cy1 <= i_centre_y;
        r_rad <= i_circle_radius;

        r_ex2  <= (2*DW)'(r_ex) * (2*DW)'(r_ex);
        r_ey2  <= (2*DW)'(r_ey) * (2*DW)'(r_ey);
        r_tx   <= (2*DW)'(r_ax) * (2*DW)'(r_ex);
        r_ty   <= (2*DW)'(r_ay) * (2*DW)'(r_ey);
        r_a2x  <= (2*DW)'(r_ax) * (2*DW)'(r_ax);
        r_a2y  <= (2*DW)'(r_ay) * (2*DW)'(r_ay);
        r_b2x  <= (2*DW)'(r_bx) * (2*DW)'(r_bx);
        r_b2y  <= (2*DW)'(r_by) * (2*DW)'(r_by);
        r_r2   <= R2W'(r_rad) * R2W'(r_rad);
        r_adx  <= QW'(r_ex[DW-1] ? -r_ex : r_ex);
        r_ady  <= QW'(r_ey[DW-1] ? -r_ey : r_ey);
        r_negx <= r_ex[DW-1];
        r_negy <= r_ey[DW-1];
        r_x0b  <= r_x0;
        r_y0b  <= r_y0;
        r_cx2  <= r_cx1;
        r_cy2  <= r_cy1;
    end

    always_comb begin
        n_t1    = TW'($unsigned(r_ex2)) + TW'($unsigned(r_ey2));
        n_t0    = (TW+1)'(r_tx) + (TW+1)'(r_ty);
        n_hit_e = (MW'($unsigned(r_a2x)) + MW'($unsigned(r_a2y)) <= MW'(r_r2)) ||
                  (MW'($unsigned(r_b2x)) + MW'($unsigned(r_b2y)) <= MW'(r_r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else begin
            r_vd[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr[0].cx    <= r_cx2;
        r_cr[0].cy    <= r_cy2;
        r_cr[0].r2    <= r_r2;
        r_cr[0].hit_e <= n_hit_e;
        r_cr[0].ok    <= (n_t1 != '0) && !n_t0[TW] && (n_t0[TW-1:0] <= n_t1);
        r_cr[0].t0    <= n_t0[TW-1:0];
        r_cr[0].t1    <= n_t1;
        r_lx[0].rem   <= '0;
        r_lx[0].quo   <= '0;
        r_lx[0].ad    <= r_adx;
        r_lx[0].neg   <= r_negx;
        r_lx[0].org   <= r_x0b;
        r_ly[0].rem   <= '0;
        r_ly[0].quo   <= '0;
        r_ly[0].ad    <= r_ady;
        r_ly[0].neg   <= r_negy;
        r_ly[0].org   <= r_y0b;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cr[k+1] <= r_cr[k];
            r_lx[k+1] <= div_step(r_lx[k], r_lx[k].ad[QW-1-k], r_cr[k].t0, r_cr[k].t1);
            r_ly[k+1] <= div_step(r_ly[k], r_ly[k].ad[QW-1-k], r_cr[k].t0, r_cr[k].t1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1       <= 1'b0;
            r_vf2       <= 1'b0;
            o_hit_valid <= 1'b0;
        end else begin
            r_vf1       <= r_vd[QW];
            r_vf2       <= r_vf1;
            o_hit_valid <= r_vf2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= PW'(r_cr[QW].cx) - proj_point(r_lx[QW]);
        r_dy   <= PW'(r_cr[QW].cy) - proj_point(r_ly[QW]);
        r_r2f1 <= r_cr[QW].r2;
        r_he1  <= r_cr[QW].hit_e;
        r_ok1  <= r_cr[QW].ok;

        r_sx   <= (2*PW)'(r_dx) * (2*PW)'(r_dx);
        r_sy   <= (2*PW)'(r_dy) * (2*PW)'(r_dy);
        r_r2f2 <= r_r2f1;
        r_he2  <= r_he1;
        r_ok2  <= r_ok1;

        o_hit  <= r_he2 ||
                  (r_ok2 && (MW'($unsigned(r_sx)) + MW'($unsigned(r_sy)) <= MW'(r_r2f2)));
    end

`ifndef SYNTH
    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_hit_valid)
        else $error("result strobe missing for accepted item");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_hit_valid)
        else $error("result strobe without accepted item");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[QW] && r_cr[QW].ok) |->
            (r_lx[QW].rem < r_cr[QW].t1) && (r_ly[QW].rem < r_cr[QW].t1))
        else $error("projection remainder not below divisor");

    a_quo_within_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[QW] && r_cr[QW].ok) |->
            (r_lx[QW].quo <= r_lx[QW].ad) && (r_ly[QW].quo <= r_ly[QW].ad))
        else $error("projection offset exceeds segment span");
`endif

endmodule
